@@ rtl/cweb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence window event builder package
// Shared widths, constants and types of the event builder.
// ----------------------------------------------------------------------------
package cweb_pkg;

   localparam int LINE_COUNT   = 15;
   localparam int LINE_W       = 4;
   localparam int TIME_W       = 48;
   localparam int ENERGY_W     = 16;
   localparam int WINDOW_W     = 32;
   localparam int ENTRY_W      = TIME_W + ENERGY_W;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 32'd1000;
   localparam logic [2:0]          ANODE_CHANNEL  = 3'd4;
   localparam logic [4:0]          ANODE_LINE_BASE = 5'd12;
   localparam logic                CMD_HIT        = 1'b0;
   localparam logic                CMD_FLUSH      = 1'b1;

   typedef logic [LINE_COUNT-1:0] mask_type;
   typedef logic [LINE_W-1:0]     line_type;
   typedef logic [TIME_W-1:0]     time_type;
   typedef logic [ENERGY_W-1:0]   energy_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CHECK   = 4'b0010,
      ST_EMIT_RD = 4'b0100,
      ST_EMIT_WR = 4'b1000
   } state_type;

endpackage

@@ rtl/cweb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data; the read
// data holds while no read is issued.
// ----------------------------------------------------------------------------
module cweb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/coincidence_window_event_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coincidence window event builder
// Groups detector hits that fall within a time window of the first hit
// into events, keeps the largest energy per detector line and emits each
// closed event as one response per filled line.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  req_      in         req_valid/req_stall cmd, hit flag, channel, group,
//                                           time, energy
//  rsp_      out        rsp_valid/rsp_stall line, time, energy, mask, last
//  csr_      in         csr_wr_en           window_ticks
//
// A hit into an empty builder is written directly; a hit into an open event
// is read, compared and written back through the line store. Closing an
// event or a flush reads out one filled line at a time through the single
// read port of the line store. Reset is synchronous; the line store needs
// no clearing since only filled lines are read. A stalled response holds
// the emission in place.
// ----------------------------------------------------------------------------
module coincidence_window_event_builder
   import cweb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic                req_hit_valid,
   input  logic [2:0]          req_channel_num,
   input  logic [1:0]          req_group_index,
   input  logic [TIME_W-1:0]   req_hit_time,
   input  logic [ENERGY_W-1:0] req_hit_energy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LINE_W-1:0]   rsp_line_number,
   output logic [TIME_W-1:0]   rsp_line_time,
   output logic [ENERGY_W-1:0] rsp_line_energy,
   output logic [LINE_COUNT-1:0] rsp_event_mask,
   output logic                rsp_last,
   input  logic                csr_wr_en,
   input  logic [WINDOW_W-1:0] csr_wr_data
);

   function automatic line_type lowest_line(input mask_type m);
      line_type idx;
      idx = '0;
      for (int i = LINE_COUNT - 1; i >= 0; i--) begin
         if (m[i]) begin
            idx = LINE_W'(i);
         end
      end
      return idx;
   endfunction

   state_type   state_ff, state_in;
   mask_type    mask_ff, mask_in;
   time_type    ref_ff, ref_in;
   logic [WINDOW_W-1:0] window_ff;
   line_type    hit_line_ff, hit_line_in;
   time_type    hit_time_ff, hit_time_in;
   energy_type  hit_energy_ff, hit_energy_in;
   time_type    diff_ff, diff_in;
   mask_type    rem_ff, rem_in;
   mask_type    emit_mask_ff, emit_mask_in;
   line_type    emit_line_ff, emit_line_in;
   logic        pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   line_type    rsp_line_ff, rsp_line_in;
   time_type    rsp_time_ff, rsp_time_in;
   energy_type  rsp_energy_ff, rsp_energy_in;
   mask_type    rsp_mask_ff, rsp_mask_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_take;
   logic [4:0]  dec_line;
   logic        dec_ok;
   logic        out_free;
   line_type    rem_low;
   mask_type    rem_low_bit;
   logic        in_window;
   logic        take_new;

   logic             ram_wr_en;
   line_type         ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   line_type         ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   time_type         rd_time;
   energy_type       rd_energy;

   cweb_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(LINE_COUNT)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_time   = ram_rd_data[ENTRY_W-1:ENERGY_W];
   assign rd_energy = ram_rd_data[ENERGY_W-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Anode channel maps past the twelve cathode lines of the three groups.
   always_comb begin
      if (req_channel_num == ANODE_CHANNEL) begin
         dec_line = {3'd0, req_group_index} + ANODE_LINE_BASE;
      end else begin
         dec_line = {1'b0, req_group_index, req_channel_num[1:0]};
      end
      dec_ok = req_hit_valid && (req_channel_num <= ANODE_CHANNEL) &&
               (dec_line < 5'(LINE_COUNT));
   end

   assign rem_low     = lowest_line(rem_ff);
   assign rem_low_bit = mask_type'(1) << rem_low;
   assign in_window   = diff_ff < {{(TIME_W-WINDOW_W){1'b0}}, window_ff};
   assign take_new    = !mask_ff[hit_line_ff] || (hit_energy_ff > rd_energy);

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      ref_in        = ref_ff;
      hit_line_in   = hit_line_ff;
      hit_time_in   = hit_time_ff;
      hit_energy_in = hit_energy_ff;
      diff_in       = diff_ff;
      rem_in        = rem_ff;
      emit_mask_in  = emit_mask_ff;
      emit_line_in  = emit_line_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_line_in   = rsp_line_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_energy_in = rsp_energy_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_line_ff;
      ram_wr_data   = {hit_time_ff, hit_energy_ff};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rem_low;

      case (state_ff)
         ST_IDLE: begin
            hit_line_in   = dec_line[LINE_W-1:0];
            hit_time_in   = req_hit_time;
            hit_energy_in = req_hit_energy;
            if (req_hit_time >= ref_ff) begin
               diff_in = req_hit_time - ref_ff;
            end else begin
               diff_in = ref_ff - req_hit_time;
            end
            if (req_take) begin
               if (req_cmd == CMD_FLUSH) begin
                  if (mask_ff != '0) begin
                     rem_in       = mask_ff;
                     emit_mask_in = mask_ff;
                     mask_in      = '0;
                     pend_in      = 1'b0;
                     state_in     = ST_EMIT_RD;
                  end
               end else if (dec_ok) begin
                  if (mask_ff == '0) begin
                     // First hit opens the event directly.
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = dec_line[LINE_W-1:0];
                     ram_wr_data = {req_hit_time, req_hit_energy};
                     mask_in     = mask_type'(1) << dec_line[LINE_W-1:0];
                     ref_in      = req_hit_time;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = dec_line[LINE_W-1:0];
                     state_in    = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (in_window) begin
               if (take_new) begin
                  ram_wr_en = 1'b1;
                  mask_in   = mask_ff | (mask_type'(1) << hit_line_ff);
               end
               state_in = ST_IDLE;
            end else begin
               // The hit waits until the closed event has been read out.
               rem_in       = mask_ff;
               emit_mask_in = mask_ff;
               mask_in      = '0;
               pend_in      = 1'b1;
               state_in     = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            ram_rd_en    = 1'b1;
            emit_line_in = rem_low;
            rem_in       = rem_ff & ~rem_low_bit;
            state_in     = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_line_in   = emit_line_ff;
               rsp_time_in   = rd_time;
               rsp_energy_in = rd_energy;
               rsp_mask_in   = emit_mask_ff;
               rsp_last_in   = (rem_ff == '0);
               if (rem_ff != '0) begin
                  ram_rd_en    = 1'b1;
                  emit_line_in = rem_low;
                  rem_in       = rem_ff & ~rem_low_bit;
               end else begin
                  if (pend_ff) begin
                     ram_wr_en = 1'b1;
                     mask_in   = mask_type'(1) << hit_line_ff;
                     ref_in    = hit_time_ff;
                     pend_in   = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         ref_ff       <= '0;
         window_ff    <= WINDOW_RESET;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         ref_ff       <= ref_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_line_ff   <= hit_line_in;
      hit_time_ff   <= hit_time_in;
      hit_energy_ff <= hit_energy_in;
      diff_ff       <= diff_in;
      emit_mask_ff  <= emit_mask_in;
      emit_line_ff  <= emit_line_in;
      rsp_line_ff   <= rsp_line_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_energy_ff <= rsp_energy_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_line_number = rsp_line_ff;
   assign rsp_line_time   = rsp_time_ff;
   assign rsp_line_energy = rsp_energy_ff;
   assign rsp_event_mask  = rsp_mask_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
